@@ rtl/core/tted_pkg.sv @@
// shared types, constants and helpers for the threshold trigger block
package tted_pkg;

    localparam int LANES       = 4;
    localparam int VALUE_WIDTH = 32;
    localparam int TIME_W      = 32;
    localparam int THR_W       = 32;
    localparam int TOL_W       = 16;
    localparam int DELAY_W     = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int PHASE_W     = 2;

    // compare width: widest operand plus room for the tolerance sums
    localparam int CMP_W = ((VALUE_WIDTH > THR_W) ? VALUE_WIDTH : THR_W) + 2;

    localparam int IN_BITS  = TIME_W + LANES + LANES * VALUE_WIDTH;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 2 + LANES + PHASE_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [2:0] {
        RULE_GT = 3'd0,
        RULE_GE = 3'd1,
        RULE_LT = 3'd2,
        RULE_LE = 3'd3,
        RULE_EQ = 3'd4,
        RULE_NE = 3'd5
    } t_rule;

    typedef enum logic [1:0] {
        EDGE_LEVEL = 2'd0,
        EDGE_RISE  = 2'd1,
        EDGE_FALL  = 2'd2,
        EDGE_BOTH  = 2'd3
    } t_edge_mode;

    typedef enum logic [PHASE_W-1:0] {
        PH_INIT  = 2'd0,
        PH_EVAL  = 2'd1,
        PH_TIMER = 2'd2,
        PH_TRIG  = 2'd3
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 3'd0,
        REG_TOLERANCE = 3'd1,
        REG_RULE      = 3'd2,
        REG_EDGE_MODE = 3'd3,
        REG_COMBINE   = 3'd4,
        REG_DELAY     = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [CMP_W-1:0] thr;
        logic signed [CMP_W-1:0] hi;
        logic signed [CMP_W-1:0] lo;
        t_rule                   rule;
    } t_lane_cfg;

    typedef struct packed {
        t_edge_mode         edge_mode;
        logic               all_mode;
        logic [DELAY_W-1:0] delay_ticks;
    } t_ctrl_cfg;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [LANES-1:0]   match_mask;
        logic               cond;
        logic               fired;
    } t_result;

    // threshold register read as a sample-width signed value
    function automatic logic signed [CMP_W-1:0] thr_extend(input logic [THR_W-1:0] v);
        logic signed [CMP_W-1:0] x;
        logic                    sgn;
        sgn = 1'b0;
        x   = '0;
        for (int i = 0; i < THR_W; i++) begin
            if (i == VALUE_WIDTH - 1) begin
                sgn = v[i];
            end
        end
        for (int i = 0; i < CMP_W; i++) begin
            if (i < VALUE_WIDTH) begin
                if (i < THR_W) begin
                    x[i] = v[i];
                end else begin
                    x[i] = 1'b0;
                end
            end else begin
                x[i] = sgn;
            end
        end
        return x;
    endfunction

endpackage

@@ rtl/core/tted_cfg.sv @@
// configuration registers and precomputed tolerance bounds
module tted_cfg import tted_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_lane_cfg             o_lane_cfg,
    output t_ctrl_cfg             o_ctrl_cfg
);

    logic [THR_W-1:0]   r_thr;
    logic [TOL_W-1:0]   r_tol;
    t_rule              r_rule;
    t_edge_mode         r_edge_mode;
    logic               r_all_mode;
    logic [DELAY_W-1:0] r_delay;
    t_lane_cfg          r_lane_cfg;
    logic signed [CMP_W-1:0] w_thr;
    logic signed [CMP_W-1:0] w_tol;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= '0;
            r_tol       <= TOL_W'(1);
            r_rule      <= RULE_GT;
            r_edge_mode <= EDGE_LEVEL;
            r_all_mode  <= 1'b0;
            r_delay     <= '0;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_THRESHOLD: r_thr       <= i_cfg_data[THR_W-1:0];
                REG_TOLERANCE: r_tol       <= i_cfg_data[TOL_W-1:0];
                REG_RULE:      r_rule      <= t_rule'(i_cfg_data[2:0]);
                REG_EDGE_MODE: r_edge_mode <= t_edge_mode'(i_cfg_data[1:0]);
                REG_COMBINE:   r_all_mode  <= i_cfg_data[0];
                REG_DELAY:     r_delay     <= i_cfg_data[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_thr = thr_extend(r_thr);
    assign w_tol = CMP_W'(signed'({1'b0, r_tol}));

    // bounds follow the registers in the next cycle, well inside the idle gap
    always_ff @(posedge i_clk) begin
        r_lane_cfg.thr  <= w_thr;
        r_lane_cfg.hi   <= w_thr + w_tol;
        r_lane_cfg.lo   <= w_thr - w_tol;
        r_lane_cfg.rule <= r_rule;
    end

    assign o_lane_cfg = r_lane_cfg;
    assign o_ctrl_cfg = '{edge_mode: r_edge_mode, all_mode: r_all_mode, delay_ticks: r_delay};

endmodule

@@ rtl/core/tted_lane.sv @@
// one entity lane: sample against threshold under the selected rule
module tted_lane import tted_pkg::*; (
    input  logic signed [VALUE_WIDTH-1:0] i_sample,
    input  t_lane_cfg                     i_cfg,
    output logic                          o_match
);

    logic signed [CMP_W-1:0] w_a;
    logic                    w_near;

    assign w_a    = CMP_W'(i_sample);
    assign w_near = (w_a == i_cfg.thr) || ((w_a > i_cfg.lo) && (w_a < i_cfg.hi));

    always_comb begin
        case (i_cfg.rule)
            RULE_GT: o_match = w_a > i_cfg.hi;
            RULE_GE: o_match = w_a >= i_cfg.lo;
            RULE_LT: o_match = w_a < i_cfg.lo;
            RULE_LE: o_match = w_a <= i_cfg.hi;
            RULE_EQ: o_match = w_near;
            RULE_NE: o_match = !w_near;
            default: o_match = 1'b0;
        endcase
    end

endmodule

@@ rtl/core/tted_merge.sv @@
// lane merge with early stop, edge qualifier, delay timer and phase state
module tted_merge import tted_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_upd,
    input  logic [TIME_W-1:0] i_time,
    input  logic [LANES-1:0]  i_active,
    input  logic [LANES-1:0]  i_res,
    input  t_ctrl_cfg         i_cfg,
    output t_result           o_result
);

    t_phase              r_phase;
    t_phase              n_phase;
    t_phase              w_ph1;
    logic                r_last;
    logic                n_last;
    logic [TIME_W-1:0]   r_timer_start;
    logic [TIME_W-1:0]   n_timer_start;
    logic [LANES-1:0]    w_hit;
    logic [LANES-1:0]    w_miss;
    logic [LANES-1:0]    w_stop;
    logic [LANES-1:0]    w_mask;
    logic                w_seen;
    logic                w_cond;
    logic                w_trig;
    logic                w_fired;
    logic [TIME_W-1:0]   w_elapsed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_INIT;
            r_last        <= 1'b0;
            r_timer_start <= '0;
        end else if (i_upd) begin
            r_phase       <= n_phase;
            r_last        <= n_last;
            r_timer_start <= n_timer_start;
        end
    end

    always_comb begin
        w_hit  = i_active & i_res;
        w_miss = i_active & ~i_res;
        w_stop = i_cfg.all_mode ? w_miss : w_hit;
        // scan from lane 0, stop at first deciding lane
        w_seen = 1'b0;
        w_mask = '0;
        for (int i = 0; i < LANES; i++) begin
            w_mask[i] = w_hit[i] & ~w_seen;
            w_seen    = w_seen | w_stop[i];
        end
        w_cond = i_cfg.all_mode ? ((|i_active) & ~(|w_miss)) : (|w_hit);

        case (i_cfg.edge_mode)
            EDGE_LEVEL: w_trig = w_cond;
            EDGE_RISE:  w_trig = (r_phase == PH_EVAL) & w_cond & ~r_last;
            EDGE_FALL:  w_trig = (r_phase == PH_EVAL) & ~w_cond & r_last;
            EDGE_BOTH:  w_trig = (r_phase == PH_EVAL) & (w_cond ^ r_last);
            default:    w_trig = 1'b0;
        endcase

        w_elapsed     = i_time - r_timer_start;
        w_ph1         = (r_phase == PH_INIT) ? PH_EVAL : r_phase;
        n_phase       = r_phase;
        n_last        = r_last;
        n_timer_start = r_timer_start;
        w_fired       = 1'b0;

        if (r_phase == PH_TIMER) begin
            // no evaluation while the delay runs
            if (w_elapsed > i_cfg.delay_ticks) begin
                n_phase = PH_TRIG;
                w_fired = 1'b1;
            end
        end else begin
            n_last = w_cond;
            if ((i_cfg.delay_ticks != '0) && w_trig && (w_ph1 == PH_EVAL)) begin
                n_timer_start = i_time;
                n_phase       = PH_TIMER;
            end else if (w_trig) begin
                n_phase = PH_TRIG;
                w_fired = 1'b1;
            end else begin
                n_phase = w_ph1;
            end
        end

        o_result.fired      = w_fired;
        o_result.cond       = (r_phase == PH_TIMER) ? 1'b0 : w_cond;
        o_result.match_mask = (r_phase == PH_TIMER) ? '0 : w_mask;
        o_result.phase      = n_phase;
    end

`ifndef ASSERT_OFF
    a_fire_enters_trig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_upd && o_result.fired) |=> (r_phase == PH_TRIG))
        else $error("fired word did not leave the block in triggered phase");

    a_timer_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_upd && (r_phase == PH_TIMER)) |-> (!o_result.cond && (o_result.match_mask == '0)))
        else $error("lane results leaked while delay running");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> ((r_phase == PH_INIT) && !r_last))
        else $error("state not cleared by reset");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_upd |=> ($stable(r_phase) && $stable(r_timer_start)))
        else $error("state changed without a word");
`endif

endmodule

@@ rtl/core/threshold_trigger_edge_delay.sv @@
// Threshold trigger with parallel entity lanes, edge qualifier and delay timer.
// Takes one word per clock and returns one result word per input word, in order;
// each word passes an input register, a lane compare register and a result
// register. The four lane comparators are combinational and the merge acts on
// each word as it enters the result register, so the sustained rate is one word
// per cycle while the output side takes words. Configuration writes reach the
// lanes via a bound register and are expected only while no word is in flight.
module threshold_trigger_edge_delay import tted_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tick_time, active_mask, sample_lane0 .. sample_lane3, zero pad
    input  logic [IN_W-1:0]       s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // fired, condition_now, match_mask, phase_out, zero pad
    output logic [OUT_W-1:0]      m_axis_tdata
);

    t_lane_cfg w_lane_cfg;
    t_ctrl_cfg w_ctrl_cfg;

    logic                          r_v1;
    logic [TIME_W-1:0]             r_time1;
    logic [LANES-1:0]              r_active1;
    logic signed [VALUE_WIDTH-1:0] r_samp1 [LANES];
    logic [LANES-1:0]              w_res;

    logic                          r_v2;
    logic [TIME_W-1:0]             r_time2;
    logic [LANES-1:0]              r_active2;
    logic [LANES-1:0]              r_res2;

    logic                          r_vo;
    t_result                       r_out;
    t_result                       w_result;

    logic w_rdy1;
    logic w_rdy2;
    logic w_rdy_o;

    tted_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_lane_cfg  (w_lane_cfg),
        .o_ctrl_cfg  (w_ctrl_cfg)
    );

    // stages advance whenever the stage after them is empty or moving
    assign w_rdy_o       = !r_vo || m_axis_tready;
    assign w_rdy2        = !r_v2 || w_rdy_o;
    assign w_rdy1        = !r_v1 || w_rdy2;
    assign s_axis_tready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy_o) begin
                r_vo <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && s_axis_tvalid) begin
            r_time1   <= s_axis_tdata[TIME_W-1:0];
            r_active1 <= s_axis_tdata[TIME_W +: LANES];
            for (int i = 0; i < LANES; i++) begin
                r_samp1[i] <= s_axis_tdata[TIME_W + LANES + i * VALUE_WIDTH +: VALUE_WIDTH];
            end
        end
        if (w_rdy2 && r_v1) begin
            r_time2   <= r_time1;
            r_active2 <= r_active1;
            r_res2    <= w_res;
        end
        if (w_rdy_o && r_v2) begin
            r_out <= w_result;
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        tted_lane u_lane (
            .i_sample (r_samp1[g]),
            .i_cfg    (w_lane_cfg),
            .o_match  (w_res[g])
        );
    end

    tted_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_upd    (r_v2 && w_rdy_o),
        .i_time   (r_time2),
        .i_active (r_active2),
        .i_res    (r_res2),
        .i_cfg    (w_ctrl_cfg),
        .o_result (w_result)
    );

    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = OUT_W'({r_out.phase, r_out.match_mask, r_out.cond, r_out.fired});

endmodule
